>>> hw/rtl/mecanum_wheel_odometry_defines.svh
// Assertion macros used by the odometry checker.
`ifndef MECANUM_WHEEL_ODOMETRY_DEFINES_SVH
`define MECANUM_WHEEL_ODOMETRY_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while reset is low.
`define MWO_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, sampled on aclk, off while reset is low.
`define MWO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

>>> hw/rtl/mwo_pkg.sv
// Types, constants and arithmetic helpers of the mecanum odometry block.
`timescale 1ns / 1ps
`default_nettype none
package mwo_pkg;

    typedef enum logic [3:0] {
        OP_IDLE, OP_LOAD, OP_SUMS, OP_MSET, OP_MUL, OP_MACC, OP_RND, OP_SHIFT,
        OP_WB, OP_HALF, OP_MID, OP_DIV, OP_DWB, OP_SUM, OP_WAIT, OP_FIN
    } op_t;

    // one entry per product the datapath forms
    typedef enum logic [3:0] {
        J_DX, J_DY, J_TOT, J_DTH, J_PH, J_R, J_R2, J_TS, J_TC, J_S,
        J_T1, J_T2, J_T3, J_T4
    } job_t;

    typedef struct packed {
        op_t        op;
        job_t       job;
        logic [1:0] part;
        logic [3:0] k;
    } cmd_t;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_MPT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RG  = 8'd1;

    localparam logic [31:0] MPT_RESET = 32'd449213718;
    localparam logic [31:0] RG_RESET  = 32'd414108773;

    localparam logic [3:0]  SERIES_TERMS = 4'd11;
    localparam logic [1:0]  LAST_PART    = 2'd3;
    localparam logic [2:0]  LAST_DIV     = 3'd7;
    localparam int          DIV_BITS     = 8;

    localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE_60DB_9391_054A;
    localparam logic [63:0] PI_Q62         = 64'hC90F_DAA2_2168_C235;
    localparam logic [63:0] ONE_Q62        = 64'h4000_0000_0000_0000;
    localparam logic [63:0] INT_MAX        = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT_MIN        = 64'h8000_0000_0000_0000;

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    // signed value from a magnitude and sign, clamped to the 64-bit range
    function automatic logic [63:0] from_mag(input logic [63:0] m, input logic neg);
        logic [63:0] r;
        if (neg) begin
            r = m[63] ? INT_MIN : (~m + 64'd1);
        end else begin
            r = m[63] ? INT_MAX : m;
        end
        return r;
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        logic [63:0] r;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            r = s[64] ? INT_MIN : INT_MAX;
        end else begin
            r = s[63:0];
        end
        return r;
    endfunction

    function automatic logic [63:0] one_minus(input logic [63:0] p);
        return (p >= ONE_Q62) ? 64'd0 : (ONE_Q62 - p);
    endfunction

    // (2k)(2k+1), divisor of the sine series term k
    function automatic logic [8:0] sin_den(input logic [3:0] k);
        logic [4:0] tk;
        tk = {k, 1'b0};
        return 9'(10'(tk) * 10'(tk + 5'd1));
    endfunction

    // (2k-1)(2k), divisor of the cosine series term k
    function automatic logic [8:0] cos_den(input logic [3:0] k);
        logic [4:0] tk;
        tk = {k, 1'b0};
        return 9'(10'(tk - 5'd1) * 10'(tk));
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/mwo_ctrl.sv
// Sequencer of the odometry block: walks the datapath through one item.
`timescale 1ns / 1ps
`default_nettype none
module mwo_ctrl
    import mwo_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    output cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_SUMS, ST_MSET, ST_MUL, ST_MACC, ST_RND, ST_SHIFT,
        ST_WB, ST_HALF, ST_MID, ST_DIV, ST_DWB, ST_SUM, ST_WAIT, ST_FIN
    } state_t;

    state_t     state_reg, state_next;
    job_t       job_reg, job_next;
    logic [1:0] part_reg, part_next;
    logic [3:0] k_reg, k_next;
    logic [2:0] dcnt_reg, dcnt_next;
    logic       s_ready_reg, s_ready_next;
    logic       m_valid_reg, m_valid_next;
    cmd_t       cmd_reg, cmd_next;
    op_t        op_next;

    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        part_next  = part_reg;
        k_next     = k_reg;
        dcnt_next  = dcnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:  state_next = ST_SUMS;
            ST_SUMS: begin
                state_next = ST_MSET;
                job_next   = J_DX;
            end
            ST_MSET: begin
                state_next = ST_MUL;
                part_next  = 2'd0;
            end
            ST_MUL:   state_next = ST_MACC;
            ST_MACC: begin
                if (part_reg == LAST_PART) begin
                    state_next = ST_RND;
                end else begin
                    part_next  = part_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_RND:   state_next = ST_SHIFT;
            ST_SHIFT: state_next = ST_WB;
            ST_WB: begin
                state_next = ST_MSET;
                case (job_reg)
                    J_DX:  job_next = J_DY;
                    J_DY:  job_next = J_TOT;
                    J_TOT: job_next = J_DTH;
                    J_DTH: state_next = ST_HALF;
                    J_PH:  job_next = J_R;
                    J_R:   job_next = J_R2;
                    J_R2: begin
                        job_next = J_TS;
                        k_next   = SERIES_TERMS;
                    end
                    J_TS, J_TC: begin
                        state_next = ST_DIV;
                        dcnt_next  = 3'd0;
                    end
                    J_S:   job_next = J_T1;
                    J_T1:  job_next = J_T2;
                    J_T2:  job_next = J_T3;
                    J_T3:  job_next = J_T4;
                    J_T4:  state_next = ST_SUM;
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_HALF:  state_next = ST_MID;
            ST_MID: begin
                state_next = ST_MSET;
                job_next   = J_PH;
            end
            ST_DIV: begin
                dcnt_next = dcnt_reg + 3'd1;
                if (dcnt_reg == LAST_DIV) begin
                    state_next = ST_DWB;
                end
            end
            ST_DWB: begin
                state_next = ST_MSET;
                if (job_reg == J_TS) begin
                    job_next = J_TC;
                end else if (k_reg == 4'd1) begin
                    job_next = J_S;
                end else begin
                    job_next = J_TS;
                    k_next   = k_reg - 4'd1;
                end
            end
            ST_SUM:   state_next = ST_WAIT;
            ST_WAIT: begin
                // pose registers are the result; only touch them once the last one left
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase

        case (state_next)
            ST_IDLE:  op_next = OP_IDLE;
            ST_LOAD:  op_next = OP_LOAD;
            ST_SUMS:  op_next = OP_SUMS;
            ST_MSET:  op_next = OP_MSET;
            ST_MUL:   op_next = OP_MUL;
            ST_MACC:  op_next = OP_MACC;
            ST_RND:   op_next = OP_RND;
            ST_SHIFT: op_next = OP_SHIFT;
            ST_WB:    op_next = OP_WB;
            ST_HALF:  op_next = OP_HALF;
            ST_MID:   op_next = OP_MID;
            ST_DIV:   op_next = OP_DIV;
            ST_DWB:   op_next = OP_DWB;
            ST_SUM:   op_next = OP_SUM;
            ST_WAIT:  op_next = OP_WAIT;
            ST_FIN:   op_next = OP_FIN;
            default:  op_next = OP_IDLE;
        endcase

        cmd_next     = '{op: op_next, job: job_next, part: part_next, k: k_next};
        s_ready_next = (state_next == ST_IDLE);
        m_valid_next = (m_valid_reg && !m_ready) || (state_reg == ST_FIN);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            job_reg     <= J_DX;
            part_reg    <= 2'd0;
            k_reg       <= SERIES_TERMS;
            dcnt_reg    <= 3'd0;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
            cmd_reg     <= '{op: OP_IDLE, job: J_DX, part: 2'd0, k: SERIES_TERMS};
        end else begin
            state_reg   <= state_next;
            job_reg     <= job_next;
            part_reg    <= part_next;
            k_reg       <= k_next;
            dcnt_reg    <= dcnt_next;
            s_ready_reg <= s_ready_next;
            m_valid_reg <= m_valid_next;
            cmd_reg     <= cmd_next;
        end
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;
    assign cmd     = cmd_reg;

endmodule
`default_nettype wire

>>> hw/rtl/mwo_datapath.sv
// Datapath: pose state, shared 32x32 multiplier, 8-bit-per-cycle divider.
`timescale 1ns / 1ps
`default_nettype none
module mwo_datapath
    import mwo_pkg::*;
#(
    parameter int POSE_FRACTION_BITS = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cmd_t                 cmd,
    input  wire logic [31:0]          s_wheel0_count,
    input  wire logic [31:0]          s_wheel1_count,
    input  wire logic [31:0]          s_wheel2_count,
    input  wire logic [31:0]          s_wheel3_count,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    output logic [63:0]               m_pose_x,
    output logic [63:0]               m_pose_y,
    output logic [63:0]               m_pose_heading
);

    localparam logic [6:0] SH_DX   = 7'(50 - POSE_FRACTION_BITS);
    localparam logic [6:0] SH_TOT  = 7'(48 - POSE_FRACTION_BITS);
    localparam logic       RND_TOT = (48 - POSE_FRACTION_BITS) > 0;
    localparam logic [6:0] SH_DTH  = 7'd30;
    localparam logic [6:0] SH_PH   = 7'(32 + POSE_FRACTION_BITS);
    localparam logic [6:0] SH_R    = 7'd31;
    localparam logic [6:0] SH_Q62  = 7'd62;

    // block state
    logic [31:0] mpt_reg, rg_reg;
    logic [31:0] prev_reg [4];
    logic        started_reg;
    logic [63:0] acc_x_reg, acc_y_reg, acc_h_reg;

    // working registers
    logic [31:0]  in_reg [4];
    logic [31:0]  d_reg [4];
    logic [33:0]  sx_reg, sy_reg, st_reg;
    logic [63:0]  a_reg, b_reg;
    logic         neg_reg, rnd_reg;
    logic [6:0]   sh_reg;
    logic [63:0]  prod_reg;
    logic [127:0] p_reg;
    logic [63:0]  res_reg;
    logic         over_reg;
    logic [63:0]  dx_reg, dy_reg, tot_reg, dth_reg, half_reg, mid_reg;
    logic [31:0]  phase_reg;
    logic [63:0]  r_reg, r2_reg, ts_reg, tc_reg, sn_reg, cs_reg;
    logic [63:0]  t1_reg, t2_reg, t3_reg, t4_reg, t12_reg, t34_reg;
    logic [63:0]  div_num_reg, div_q_reg;
    logic [8:0]   div_rem_reg, div_den_reg;

    // combinational
    logic [33:0]  de [4];
    logic [33:0]  sx_w, sy_w, st_w;
    logic [33:0]  sxm, sym, stm;
    logic [63:0]  op_a, op_b;
    logic         op_neg, op_rnd;
    logic [6:0]   op_sh;
    logic [63:0]  ndy_mag;
    logic         ndy_neg;
    logic [31:0]  a_half, b_half;
    logic [1:0]   psum;
    logic [127:0] prod_ext, shifted;
    logic [63:0]  sat_val;
    logic [63:0]  num_w, q_w;
    logic [8:0]   rem_w;
    logic [9:0]   trial;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            de[i] = {{2{d_reg[i][31]}}, d_reg[i]};
        end
        sx_w = de[0] - de[1] + de[2] - de[3];
        sy_w = de[2] + de[3] - de[0] - de[1];
        st_w = de[0] + de[1] + de[2] + de[3];
        sxm  = sx_reg[33] ? (~sx_reg + 34'd1) : sx_reg;
        sym  = sy_reg[33] ? (~sy_reg + 34'd1) : sy_reg;
        stm  = st_reg[33] ? (~st_reg + 34'd1) : st_reg;

        // -dy with the most negative value clamped
        ndy_mag = (dy_reg == INT_MIN) ? INT_MAX : mag64(dy_reg);
        ndy_neg = !dy_reg[63] && (dy_reg != 64'd0);

        op_a = 64'd0;
        op_b = 64'd0;
        op_neg = 1'b0;
        op_sh = SH_Q62;
        op_rnd = 1'b0;
        case (cmd.job)
            J_DX: begin
                op_a = 64'(sxm); op_b = 64'(mpt_reg); op_neg = sx_reg[33];
                op_sh = SH_DX; op_rnd = 1'b1;
            end
            J_DY: begin
                op_a = 64'(sym); op_b = 64'(mpt_reg); op_neg = sy_reg[33];
                op_sh = SH_DX; op_rnd = 1'b1;
            end
            J_TOT: begin
                op_a = 64'(stm); op_b = 64'(mpt_reg); op_neg = st_reg[33];
                op_sh = SH_TOT; op_rnd = RND_TOT;
            end
            J_DTH: begin
                op_a = mag64(tot_reg); op_b = 64'(rg_reg); op_neg = tot_reg[63];
                op_sh = SH_DTH; op_rnd = 1'b1;
            end
            J_PH: begin
                op_a = mag64(mid_reg); op_b = INV_TWO_PI_Q64; op_sh = SH_PH;
            end
            J_R: begin
                op_a = {34'd0, phase_reg[29:0]}; op_b = PI_Q62; op_sh = SH_R;
            end
            J_R2: begin
                op_a = r_reg; op_b = r_reg;
            end
            J_TS: begin
                op_a = r2_reg; op_b = ts_reg;
            end
            J_TC: begin
                op_a = r2_reg; op_b = tc_reg;
            end
            J_S: begin
                op_a = r_reg; op_b = ts_reg;
            end
            J_T1: begin
                op_a = mag64(dx_reg); op_b = mag64(cs_reg);
                op_neg = dx_reg[63] ^ cs_reg[63]; op_rnd = 1'b1;
            end
            J_T2: begin
                op_a = ndy_mag; op_b = mag64(sn_reg);
                op_neg = ndy_neg ^ sn_reg[63]; op_rnd = 1'b1;
            end
            J_T3: begin
                op_a = mag64(dx_reg); op_b = mag64(sn_reg);
                op_neg = dx_reg[63] ^ sn_reg[63]; op_rnd = 1'b1;
            end
            J_T4: begin
                op_a = mag64(dy_reg); op_b = mag64(cs_reg);
                op_neg = dy_reg[63] ^ cs_reg[63]; op_rnd = 1'b1;
            end
            default: begin
                op_a = 64'd0;
            end
        endcase

        a_half   = cmd.part[0] ? a_reg[63:32] : a_reg[31:0];
        b_half   = cmd.part[1] ? b_reg[63:32] : b_reg[31:0];
        psum     = {1'b0, cmd.part[0]} + {1'b0, cmd.part[1]};
        prod_ext = {64'd0, prod_reg} << {psum, 5'd0};
        shifted  = p_reg >> sh_reg;
        sat_val  = from_mag(over_reg ? INT_MIN : res_reg, neg_reg);

        // restoring division, DIV_BITS quotient bits per cycle
        num_w = div_num_reg;
        q_w   = div_q_reg;
        rem_w = div_rem_reg;
        trial = 10'd0;
        for (int i = 0; i < DIV_BITS; i++) begin
            trial = {rem_w, num_w[63]};
            num_w = {num_w[62:0], 1'b0};
            if (trial >= {1'b0, div_den_reg}) begin
                rem_w = 9'(trial - {1'b0, div_den_reg});
                q_w   = {q_w[62:0], 1'b1};
            end else begin
                rem_w = trial[8:0];
                q_w   = {q_w[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mpt_reg     <= MPT_RESET;
            rg_reg      <= RG_RESET;
            started_reg <= 1'b0;
            acc_x_reg   <= 64'd0;
            acc_y_reg   <= 64'd0;
            acc_h_reg   <= 64'd0;
            for (int i = 0; i < 4; i++) begin
                prev_reg[i] <= 32'd0;
            end
        end else begin
            if (cfg_valid) begin
                if (cfg_index == REG_MPT) begin
                    mpt_reg <= cfg_data;
                end else if (cfg_index == REG_RG) begin
                    rg_reg <= cfg_data;
                end
            end
            if (cmd.op == OP_LOAD) begin
                started_reg <= 1'b1;
                for (int i = 0; i < 4; i++) begin
                    prev_reg[i] <= in_reg[i];
                end
            end
            if (cmd.op == OP_FIN) begin
                acc_x_reg <= sat_add(acc_x_reg, t12_reg);
                acc_y_reg <= sat_add(acc_y_reg, t34_reg);
                acc_h_reg <= sat_add(acc_h_reg, dth_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_IDLE: begin
                in_reg[0] <= s_wheel0_count;
                in_reg[1] <= s_wheel1_count;
                in_reg[2] <= s_wheel2_count;
                in_reg[3] <= s_wheel3_count;
            end
            OP_LOAD: begin
                // first item only latches the counts
                for (int i = 0; i < 4; i++) begin
                    d_reg[i] <= started_reg ? (in_reg[i] - prev_reg[i]) : 32'd0;
                end
            end
            OP_SUMS: begin
                sx_reg <= sx_w;
                sy_reg <= sy_w;
                st_reg <= st_w;
            end
            OP_MSET: begin
                a_reg   <= op_a;
                b_reg   <= op_b;
                neg_reg <= op_neg;
                sh_reg  <= op_sh;
                rnd_reg <= op_rnd;
                p_reg   <= 128'd0;
            end
            OP_MUL:   prod_reg <= 64'(a_half) * 64'(b_half);
            OP_MACC:  p_reg <= p_reg + prod_ext;
            OP_RND: begin
                if (rnd_reg) begin
                    p_reg <= p_reg + (128'd1 << (sh_reg - 7'd1));
                end
            end
            OP_SHIFT: begin
                res_reg  <= shifted[63:0];
                over_reg <= |shifted[127:64];
            end
            OP_WB: begin
                case (cmd.job)
                    J_DX:  dx_reg  <= sat_val;
                    J_DY:  dy_reg  <= sat_val;
                    J_TOT: tot_reg <= sat_val;
                    J_DTH: dth_reg <= sat_val;
                    J_PH:  phase_reg <= mid_reg[63] ? (32'd0 - res_reg[31:0]) : res_reg[31:0];
                    J_R:   r_reg <= res_reg;
                    J_R2: begin
                        r2_reg <= res_reg;
                        ts_reg <= ONE_Q62;
                        tc_reg <= ONE_Q62;
                    end
                    J_TS, J_TC: begin
                        div_num_reg <= res_reg;
                        div_rem_reg <= 9'd0;
                        div_den_reg <= (cmd.job == J_TS) ? sin_den(cmd.k) : cos_den(cmd.k);
                    end
                    J_S: begin
                        // quadrant from the top two phase bits
                        case (phase_reg[31:30])
                            2'd0: begin sn_reg <= res_reg; cs_reg <= tc_reg; end
                            2'd1: begin sn_reg <= tc_reg; cs_reg <= 64'd0 - res_reg; end
                            2'd2: begin
                                sn_reg <= 64'd0 - res_reg; cs_reg <= 64'd0 - tc_reg;
                            end
                            default: begin sn_reg <= 64'd0 - tc_reg; cs_reg <= res_reg; end
                        endcase
                    end
                    J_T1: t1_reg <= sat_val;
                    J_T2: t2_reg <= sat_val;
                    J_T3: t3_reg <= sat_val;
                    J_T4: t4_reg <= sat_val;
                    default: t4_reg <= t4_reg;
                endcase
            end
            OP_HALF: begin
                // halve toward zero
                half_reg <= {dth_reg[63], dth_reg[63:1]} + 64'(dth_reg[63] & dth_reg[0]);
            end
            OP_MID:   mid_reg <= sat_add(acc_h_reg, half_reg);
            OP_DIV: begin
                div_num_reg <= num_w;
                div_q_reg   <= q_w;
                div_rem_reg <= rem_w;
            end
            OP_DWB: begin
                if (cmd.job == J_TS) begin
                    ts_reg <= one_minus(div_q_reg);
                end else begin
                    tc_reg <= one_minus(div_q_reg);
                end
            end
            OP_SUM: begin
                t12_reg <= sat_add(t1_reg, t2_reg);
                t34_reg <= sat_add(t3_reg, t4_reg);
            end
            default: begin
                res_reg <= res_reg;
            end
        endcase
    end

    assign m_pose_x       = acc_x_reg;
    assign m_pose_y       = acc_y_reg;
    assign m_pose_heading = acc_h_reg;

endmodule
`default_nettype wire

>>> hw/rtl/mecanum_wheel_odometry.sv
// Top level of the mecanum four-wheel dead-reckoning odometry block.
`timescale 1ns / 1ps
`default_nettype none
// One item of four encoder counts yields one pose item (x, y, heading in signed
// Q(63-F).F, F = POSE_FRACTION_BITS, saturating); the first item after reset
// only latches the counts. Every product goes through one shared 32x32
// multiplier as four partial products (34 products per item), and the 22
// series divisions run through a divider that retires 8 quotient bits a cycle.
// s_ready is high only between items, while a finished result may still wait
// on m_ready. Configuration writes are taken at any time (cfg_ready is always
// high) and belong between items.
module mecanum_wheel_odometry
    import mwo_pkg::*;
#(
    parameter int POSE_FRACTION_BITS = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [31:0]          s_wheel0_count,
    input  wire logic [31:0]          s_wheel1_count,
    input  wire logic [31:0]          s_wheel2_count,
    input  wire logic [31:0]          s_wheel3_count,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic signed [63:0]        m_pose_x,
    output logic signed [63:0]        m_pose_y,
    output logic signed [63:0]        m_pose_heading,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    cmd_t cmd;

    assign cfg_ready = 1'b1;

    mwo_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    mwo_datapath #(
        .POSE_FRACTION_BITS (POSE_FRACTION_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_wheel0_count (s_wheel0_count),
        .s_wheel1_count (s_wheel1_count),
        .s_wheel2_count (s_wheel2_count),
        .s_wheel3_count (s_wheel3_count),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .m_pose_x       (m_pose_x),
        .m_pose_y       (m_pose_y),
        .m_pose_heading (m_pose_heading)
    );

endmodule
`default_nettype wire

>>> hw/rtl/mwo_checker.sv
// Port-level checks of the odometry block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "mecanum_wheel_odometry_defines.svh"
module mwo_checker
    import mwo_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire logic [31:0]          s_wheel0_count,
    input wire logic [31:0]          s_wheel1_count,
    input wire logic [31:0]          s_wheel2_count,
    input wire logic [31:0]          s_wheel3_count,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire logic signed [63:0]   m_pose_x,
    input wire logic signed [63:0]   m_pose_y,
    input wire logic signed [63:0]   m_pose_heading,
    input wire logic                 cfg_valid,
    input wire logic                 cfg_ready,
    input wire logic [CFG_IDX_W-1:0] cfg_index,
    input wire logic [31:0]          cfg_data
);

    // a stalled result holds
    `MWO_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_pose_x) && $stable(m_pose_y) && $stable(m_pose_heading))

    // one item in flight: input closes right after an item is taken
    `MWO_ASSERT_NEXT(a_one_item, s_valid && s_ready, !s_ready)

    // a new result only comes at the end of an item's work
    `MWO_ASSERT_NOW(a_fresh_result, $rose(m_valid), $past(!s_ready))

    // pose stays put unless a new result shows up
    `MWO_ASSERT_NEXT(a_pose_quiet, !m_valid, m_valid || ($stable(m_pose_x) && $stable(m_pose_y) && $stable(m_pose_heading)))

endmodule

bind mecanum_wheel_odometry mwo_checker u_mwo_checker (.*);
`default_nettype wire
